### rtl/core/ccr_pkg.sv
`timescale 1ns / 1ps

package ccr_pkg;

    localparam int NUM_CHUNKS_DEF = 8;

    localparam int OFFSET_W   = 32;
    localparam int CHUNK_W    = 21;
    localparam int COUNT_W    = 4;
    localparam int OIC_W      = 20;
    localparam int CIDX_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    // Working width for the clamped entry count; holds any supported NUM_CHUNKS.
    localparam int CNT_CALC_W = 8;

    localparam logic [CHUNK_W-1:0]  CHUNK_SIZE_RESET    = 21'd4096;
    localparam logic [OFFSET_W-1:0] FILE_LENGTH_RESET   = 32'd0;
    localparam logic [COUNT_W-1:0]  CHUNKS_IN_USE_RESET = 4'd8;

    localparam logic [7:0] WINDOW_SPAN   = 8'hff;
    localparam int         BACKOFF_SHIFT = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_SIZE    = 2'd0,
        CFG_FILE_LENGTH   = 2'd1,
        CFG_CHUNKS_IN_USE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic scan_next;
        logic walk_init;
        logic walk_step;
        logic calc_start;
        logic calc_limit;
        logic commit_hit;
        logic commit_miss;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic hit_now;
        logic scan_last;
        logic hand_free;
    } t_dp_sts;

    typedef struct packed {
        logic                  hit;
        logic [CIDX_W-1:0]     chunk_index;
        logic [OIC_W-1:0]      offset_in_chunk;
        logic                  fill_request;
        logic [OFFSET_W-1:0]   fill_start;
        logic [CHUNK_W-1:0]    fill_length;
        logic                  failed;
    } t_result;

endpackage

### rtl/core/ccr_if.sv
`timescale 1ns / 1ps

interface ccr_req_if;
    import ccr_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [OFFSET_W-1:0] file_offset;

    modport source (output valid, output opcode, output file_offset, input ready);
    modport sink   (input valid, input opcode, input file_offset, output ready);
endinterface

interface ccr_rsp_if;
    import ccr_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [CIDX_W-1:0]   chunk_index;
    logic [OIC_W-1:0]    offset_in_chunk;
    logic                fill_request;
    logic [OFFSET_W-1:0] fill_start;
    logic [CHUNK_W-1:0]  fill_length;
    logic                failed;

    modport source (output valid, output hit, output chunk_index, output offset_in_chunk,
                    output fill_request, output fill_start, output fill_length,
                    output failed, input ready);
    modport sink   (input valid, input hit, input chunk_index, input offset_in_chunk,
                    input fill_request, input fill_start, input fill_length,
                    input failed, output ready);
endinterface

### rtl/core/ccr_ram.sv
`timescale 1ns / 1ps

module ccr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ccr_ctrl.sv
`timescale 1ns / 1ps

module ccr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ccr_pkg::t_dp_cmd o_cmd,
    input  ccr_pkg::t_dp_sts i_sts
);
    import ccr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_CALC_START,
        S_CALC_LIMIT,
        S_COMMIT,
        S_EMIT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_vld;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit_now) begin
                    cmd.commit_hit = 1'b1;
                    n_state        = S_EMIT;
                end else if (i_sts.scan_last) begin
                    cmd.walk_init = 1'b1;
                    n_state       = S_WALK;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_WALK: begin
                if (i_sts.hand_free) begin
                    n_state = S_CALC_START;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_CALC_START: begin
                cmd.calc_start = 1'b1;
                n_state        = S_CALC_LIMIT;
            end
            S_CALC_LIMIT: begin
                cmd.calc_limit = 1'b1;
                n_state        = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit_miss = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                // The result register is free once its current transaction completes.
                if (!r_out_vld || i_out_ready) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!r_out_vld || i_out_ready))
        else $error("result register loaded over an untaken result");

    a_walk_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !i_sts.hand_free)
        else $error("clock hand advanced past a free entry");

    a_out_from_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit state");

endmodule

### rtl/core/ccr_dp.sv
`timescale 1ns / 1ps

module ccr_dp #(
    parameter int NUM_CHUNKS = ccr_pkg::NUM_CHUNKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ccr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_opcode,
    input  logic [ccr_pkg::OFFSET_W-1:0]     i_file_offset,
    input  ccr_pkg::t_dp_cmd                 i_cmd,
    output ccr_pkg::t_dp_sts                 o_sts,
    output ccr_pkg::t_result                 o_res
);
    import ccr_pkg::*;

    localparam int IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int TAG_W = 2 * OFFSET_W;

    // Configuration registers
    logic [CHUNK_W-1:0]  r_chunk_size;
    logic [OFFSET_W-1:0] r_file_length;
    logic [COUNT_W-1:0]  r_chunks_in_use;

    // Request and working registers
    logic                r_op;
    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W:0]   r_need;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_hand;
    logic [OFFSET_W-1:0] r_start;
    logic [OFFSET_W-1:0] r_limit;
    logic                r_used [NUM_CHUNKS];
    logic                r_vld  [NUM_CHUNKS];
    t_result             r_res;
    t_result             n_res;
    t_result             r_out;

    logic [CNT_CALC_W-1:0] cnt;
    logic [IDX_W-1:0]      last_idx;
    logic [IDX_W-1:0]      tag_raddr;
    logic [TAG_W-1:0]      tag_rdata;
    logic                  tag_we;
    logic [OFFSET_W-1:0]   ent_start;
    logic [OFFSET_W-1:0]   ent_limit;
    logic [OFFSET_W-1:0]   hit_diff;
    logic                  hit_now;
    logic [OFFSET_W-1:0]   back;
    logic [OFFSET_W:0]     sum;
    logic                  fail;
    logic [OFFSET_W-1:0]   len_full;
    logic [OFFSET_W-1:0]   miss_diff;

    function automatic logic [CIDX_W-1:0] to_cidx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+CIDX_W-1:0] ext;
        ext = {{CIDX_W{1'b0}}, idx};
        return ext[CIDX_W-1:0];
    endfunction

    // A count of zero acts as one; a count above the table size is clamped.
    always_comb begin
        cnt = {{(CNT_CALC_W-COUNT_W){1'b0}}, r_chunks_in_use};
        if (cnt == '0) begin
            cnt = CNT_CALC_W'(1);
        end else if (cnt > CNT_CALC_W'(NUM_CHUNKS)) begin
            cnt = CNT_CALC_W'(NUM_CHUNKS);
        end
        last_idx = IDX_W'(cnt - CNT_CALC_W'(1));
    end

    // The read for the next entry is issued while the current one is compared.
    always_comb begin
        if (i_cmd.start) begin
            tag_raddr = '0;
        end else if (r_idx == last_idx) begin
            tag_raddr = r_idx;
        end else begin
            tag_raddr = r_idx + IDX_W'(1);
        end
    end

    assign fail   = r_op && ({1'b0, r_limit} <= r_need);
    assign tag_we = i_cmd.commit_miss && !fail;

    ccr_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_CHUNKS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_hand),
        .i_wdata ({r_start, r_limit}),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // An entry never written reads as an empty window at zero.
    always_comb begin
        if (r_vld[r_idx]) begin
            ent_start = tag_rdata[TAG_W-1:OFFSET_W];
            ent_limit = tag_rdata[OFFSET_W-1:0];
        end else begin
            ent_start = '0;
            ent_limit = '0;
        end
        hit_diff = r_offset - ent_start;
        hit_now  = (ent_start <= r_offset) && ({1'b0, ent_limit} > r_need);
    end

    assign back      = {{(OFFSET_W-CHUNK_W){1'b0}}, r_chunk_size >> BACKOFF_SHIFT};
    assign sum       = {1'b0, r_start} + {{(OFFSET_W+1-CHUNK_W){1'b0}}, r_chunk_size};
    assign len_full  = (r_limit > r_start) ? (r_limit - r_start) : '0;
    assign miss_diff = r_offset - r_start;

    always_comb begin
        n_res = r_res;
        if (i_cmd.commit_hit) begin
            n_res                 = '0;
            n_res.hit             = 1'b1;
            n_res.chunk_index     = to_cidx(r_idx);
            n_res.offset_in_chunk = hit_diff[OIC_W-1:0];
        end else if (i_cmd.commit_miss) begin
            n_res             = '0;
            n_res.chunk_index = to_cidx(r_hand);
            if (fail) begin
                n_res.failed = 1'b1;
            end else begin
                n_res.fill_request    = 1'b1;
                n_res.offset_in_chunk = miss_diff[OIC_W-1:0];
                n_res.fill_start      = r_start;
                n_res.fill_length     = len_full[CHUNK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size    <= CHUNK_SIZE_RESET;
            r_file_length   <= FILE_LENGTH_RESET;
            r_chunks_in_use <= CHUNKS_IN_USE_RESET;
            r_idx           <= '0;
            r_hand          <= '0;
            for (int i = 0; i < NUM_CHUNKS; i++) begin
                r_used[i] <= 1'b0;
                r_vld[i]  <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHUNK_SIZE:    r_chunk_size    <= i_cfg_data[CHUNK_W-1:0];
                    CFG_FILE_LENGTH:   r_file_length   <= i_cfg_data[OFFSET_W-1:0];
                    CFG_CHUNKS_IN_USE: r_chunks_in_use <= i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start) begin
                r_idx <= '0;
            end else if (i_cmd.scan_next) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.walk_init && (r_hand > last_idx)) begin
                r_hand <= '0;
            end else if (i_cmd.walk_step) begin
                r_used[r_hand] <= 1'b0;
                r_hand         <= (r_hand == last_idx) ? '0 : r_hand + IDX_W'(1);
            end
            if (i_cmd.commit_hit) begin
                r_used[r_idx] <= 1'b1;
            end
            if (tag_we) begin
                r_used[r_hand] <= 1'b1;
                r_vld[r_hand]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_opcode;
            r_offset <= i_file_offset;
            r_need   <= {1'b0, i_file_offset}
                      + (i_opcode ? {{(OFFSET_W-7){1'b0}}, WINDOW_SPAN} : '0);
        end
        if (i_cmd.calc_start) begin
            r_start <= (r_offset >= back) ? (r_offset - back) : '0;
        end
        if (i_cmd.calc_limit) begin
            r_limit <= (sum > {1'b0, r_file_length}) ? r_file_length : sum[OFFSET_W-1:0];
        end
        r_res <= n_res;
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_sts.hit_now   = hit_now;
    assign o_sts.scan_last = (r_idx == last_idx);
    assign o_sts.hand_free = !r_used[r_hand];
    assign o_res           = r_out;

    a_hit_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_hit |=> (r_res.hit && !r_res.fill_request && !r_res.failed))
        else $error("hit result carries a fill or a failure");

    a_miss_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_miss |=> (!r_res.hit && (r_res.fill_request != r_res.failed)))
        else $error("miss result must be exactly one of fill or failure");

    a_hand_stays : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_miss |=> (r_hand == $past(r_hand)))
        else $error("clock hand moved off the victim");

endmodule

### rtl/core/chunk_cache_clock_replacement.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   opcode, file_offset
// o_rsp     out  valid/ready   hit, chunk_index, offset_in_chunk, fill_request,
//                              fill_start, fill_length, failed
// i_cfg_*   in   write enable  register index, write data (no read-back)
//
// A request is compared against one tag entry per cycle through the single read
// port of the tag RAM. A hit is committed from the scan state and then emitted.
// A miss scans every entry in use, walks the clock hand to a free entry, computes
// the window start and then its limit, commits the result and then emits it.
// Reset is synchronous and clears tags (valid bits), used bits and the hand.
// A new request is taken as soon as the engine is idle, even while the previous
// result still waits; the engine stalls only if that result is still untaken.

module chunk_cache_clock_replacement #(
    parameter int NUM_CHUNKS = ccr_pkg::NUM_CHUNKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ccr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ccr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ccr_req_if.sink                        i_req,
    ccr_rsp_if.source                      o_rsp
);
    import ccr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result res;
    logic    in_ready;
    logic    out_valid;

    ccr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ccr_dp #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_req.opcode),
        .i_file_offset (i_req.file_offset),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_res         (res)
    );

    assign i_req.ready           = in_ready;
    assign o_rsp.valid           = out_valid;
    assign o_rsp.hit             = res.hit;
    assign o_rsp.chunk_index     = res.chunk_index;
    assign o_rsp.offset_in_chunk = res.offset_in_chunk;
    assign o_rsp.fill_request    = res.fill_request;
    assign o_rsp.fill_start      = res.fill_start;
    assign o_rsp.fill_length     = res.fill_length;
    assign o_rsp.failed          = res.failed;

endmodule
